FILE: rtl/core/psrs_pkg.sv
`default_nettype none

package psrs_pkg;

  // Fixed field widths.
  localparam int CMD_W   = 3;
  localparam int CODE_W  = 3;
  localparam int EVT_W   = 2;
  localparam int SECS_W  = 10;
  localparam int REG_W   = 20;
  localparam int RIDX_W  = 2;

  // Register indexes on the configuration port.
  localparam logic [RIDX_W-1:0] REG_STARTER_TIME = 2'd0;
  localparam logic [RIDX_W-1:0] REG_STOP_PULSE   = 2'd1;
  localparam logic [RIDX_W-1:0] REG_COOLDOWN     = 2'd2;
  localparam logic [RIDX_W-1:0] REG_GRACE        = 2'd3;

  // Register values after reset, in milliseconds.
  localparam logic [REG_W-1:0] STARTER_TIME_RST = 20'd3000;
  localparam logic [REG_W-1:0] STOP_PULSE_RST   = 20'd500;
  localparam logic [REG_W-1:0] COOLDOWN_RST     = 20'd170000;
  localparam logic [REG_W-1:0] GRACE_RST        = 20'd2000;

  // Seconds are reported up to this ceiling.
  localparam logic [SECS_W-1:0] SECS_MAX = 10'd1000;

  // Division by 1000 as a multiply by ceil(2^30 / 1000) and a shift by 30.
  // The rounding error times the largest 20-bit dividend stays below 2^30,
  // so the quotient is exact over the whole register range.
  localparam int                 DIV_SHIFT = 30;
  localparam logic [20:0]        DIV_RECIP = 21'd1073742;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ON     = 3'd1,
    CMD_OFF    = 3'd2,
    CMD_LOCK   = 3'd3,
    CMD_UNLOCK = 3'd4
  } cmd_t;

  typedef enum logic [CODE_W-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_STARTING = 3'd1,
    MODE_RUNNING  = 3'd2,
    MODE_STOPPING = 3'd3,
    MODE_COOLDOWN = 3'd4,
    MODE_LOCKED   = 3'd5
  } mode_t;

  typedef enum logic [CODE_W-1:0] {
    RES_OK          = 3'd0,
    RES_ALREADY_ON  = 3'd1,
    RES_ALREADY_OFF = 3'd2,
    RES_COOLDOWN    = 3'd3,
    RES_LOCKED      = 3'd4
  } res_t;

  typedef enum logic [EVT_W-1:0] {
    EVT_NONE     = 2'd0,
    EVT_CD_START = 2'd1,
    EVT_CD_END   = 2'd2
  } evt_t;

  // Whole seconds of a millisecond count, saturated at the ceiling.
  function automatic logic [SECS_W-1:0] ms_to_secs(input logic [REG_W-1:0] ms);
    logic [40:0] prod;
    logic [10:0] quot;
    prod = {21'd0, ms} * {20'd0, DIV_RECIP};
    quot = prod[40:DIV_SHIFT];
    return (quot > {1'b0, SECS_MAX}) ? SECS_MAX : quot[SECS_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/psrs_chan_if.sv
`default_nettype none

// Input channel: a command with the motor feedback.
interface psrs_in_if;
  logic                       valid;
  logic                       ready;
  logic [psrs_pkg::CMD_W-1:0] command;
  logic                       motor_running;

  modport source (output valid, command, motor_running, input ready);
  modport sink   (input valid, command, motor_running, output ready);
endinterface

// Result channel: status, relay drives and cooldown information.
interface psrs_out_if;
  logic                        valid;
  logic                        ready;
  logic [psrs_pkg::CODE_W-1:0] result_code;
  logic [psrs_pkg::CODE_W-1:0] state_code;
  logic                        starter_relay;
  logic                        coil_relay;
  logic                        stop_relay;
  logic [psrs_pkg::EVT_W-1:0]  event_code;
  logic [psrs_pkg::SECS_W-1:0] event_seconds;
  logic [psrs_pkg::SECS_W-1:0] cooldown_left_s;

  modport source (output valid, result_code, state_code, starter_relay, coil_relay,
                  stop_relay, event_code, event_seconds, cooldown_left_s, input ready);
  modport sink   (input valid, result_code, state_code, starter_relay, coil_relay,
                  stop_relay, event_code, event_seconds, cooldown_left_s, output ready);
endinterface

// Configuration write channel.
interface psrs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [psrs_pkg::RIDX_W-1:0] reg_index;
  logic [psrs_pkg::REG_W-1:0]  wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pump_starter_relay_sequencer_unit.sv
// An input transfer's result passes through the state stage, then the output register,
// before it is offered on the result channel.
// Throughput: one item per cycle while the result channel takes results. The state stage
// can take an input while a result waits in the output register; input stalls once both
// hold a result. Configuration writes take effect in the cycle after their transfer.
// Reset (rst_n low, synchronous): state idle, counter, relays and pipeline valid flags cleared.
`default_nettype none

module pump_starter_relay_sequencer_unit #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  psrs_in_if.sink        in_ch,
  psrs_out_if.source     out_ch,
  psrs_cfg_if.sink       cfg_ch
);

  localparam int REG_W = psrs_pkg::REG_W;
  localparam int CMP_W = (COUNT_BITS > REG_W) ? COUNT_BITS : REG_W;

  // Configuration registers.
  logic [REG_W-1:0] starter_time_r, stop_pulse_r, cooldown_r, grace_r;

  // Sequencer state.
  psrs_pkg::mode_t       mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic                  starter_r, starter_nxt;
  logic                  coil_r, coil_nxt;
  logic                  stop_r, stop_nxt;

  // State stage: result fields before the seconds conversion.
  logic                  s1_v_r;
  psrs_pkg::res_t        s1_res_r, res_nxt;
  psrs_pkg::mode_t       s1_mode_r;
  logic                  s1_starter_r, s1_coil_r, s1_stop_r;
  psrs_pkg::evt_t        s1_evt_r, evt_nxt;
  logic [REG_W-1:0]      s1_evt_ms_r, evt_ms_nxt;
  logic [REG_W-1:0]      s1_left_ms_r, left_ms_nxt;

  // Output register.
  logic                          out_v_r;
  psrs_pkg::res_t                out_res_r;
  psrs_pkg::mode_t               out_mode_r;
  logic                          out_starter_r, out_coil_r, out_stop_r;
  psrs_pkg::evt_t                out_evt_r;
  logic [psrs_pkg::SECS_W-1:0]   out_evt_s_r, out_left_s_r;

  logic            in_acc, s2_ld, cfg_acc;
  psrs_pkg::cmd_t  cmd;
  logic [CMP_W-1:0] inc_ext, nxt_ext, left_diff;

  // Pipeline flow control.
  assign s2_ld       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s2_ld;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_acc     = cfg_ch.valid;
  assign cmd         = psrs_pkg::cmd_t'(in_ch.command);

  // Saturating millisecond counter.
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + COUNT_BITS'(1);
  assign inc_ext     = CMP_W'(elapsed_inc);

  // Next state.
  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    starter_nxt = starter_r;
    coil_nxt    = coil_r;
    stop_nxt    = stop_r;
    case (cmd)
      psrs_pkg::CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        case (mode_r)
          psrs_pkg::MODE_STARTING: begin
            if (inc_ext >= CMP_W'(starter_time_r)) begin
              starter_nxt = 1'b0;
              mode_nxt    = psrs_pkg::MODE_RUNNING;
            end
          end
          psrs_pkg::MODE_RUNNING: begin
            if ((inc_ext > CMP_W'(grace_r)) && !in_ch.motor_running) begin
              starter_nxt = 1'b0;
              coil_nxt    = 1'b0;
              stop_nxt    = 1'b0;
              mode_nxt    = psrs_pkg::MODE_COOLDOWN;
            end
          end
          psrs_pkg::MODE_STOPPING: begin
            if (inc_ext >= CMP_W'(stop_pulse_r)) begin
              stop_nxt = 1'b0;
              mode_nxt = psrs_pkg::MODE_COOLDOWN;
            end
          end
          psrs_pkg::MODE_COOLDOWN: begin
            if (inc_ext >= CMP_W'(cooldown_r)) begin
              mode_nxt = psrs_pkg::MODE_IDLE;
            end
          end
          default: ;
        endcase
      end
      psrs_pkg::CMD_ON: begin
        if (mode_r == psrs_pkg::MODE_IDLE) begin
          starter_nxt = 1'b1;
          coil_nxt    = 1'b1;
          mode_nxt    = psrs_pkg::MODE_STARTING;
        end
      end
      psrs_pkg::CMD_OFF: begin
        if (mode_r == psrs_pkg::MODE_STARTING || mode_r == psrs_pkg::MODE_RUNNING) begin
          starter_nxt = 1'b0;
          coil_nxt    = 1'b0;
          stop_nxt    = 1'b1;
          mode_nxt    = psrs_pkg::MODE_STOPPING;
        end
      end
      psrs_pkg::CMD_LOCK: begin
        starter_nxt = 1'b0;
        coil_nxt    = 1'b0;
        stop_nxt    = 1'b1;
        mode_nxt    = psrs_pkg::MODE_LOCKED;
      end
      psrs_pkg::CMD_UNLOCK: begin
        if (mode_r == psrs_pkg::MODE_LOCKED) begin
          stop_nxt = 1'b0;
          mode_nxt = psrs_pkg::MODE_IDLE;
        end
      end
      default: ;
    endcase
    // Entering a state, including lock while locked, restarts the counter.
    if (mode_nxt != mode_r || cmd == psrs_pkg::CMD_LOCK) begin
      elapsed_nxt = '0;
    end
  end

  // Result code, event and the millisecond values to convert.
  always_comb begin
    res_nxt = psrs_pkg::RES_OK;
    case (cmd)
      psrs_pkg::CMD_ON: begin
        if (mode_r inside {psrs_pkg::MODE_STARTING, psrs_pkg::MODE_RUNNING}) begin
          res_nxt = psrs_pkg::RES_ALREADY_ON;
        end else if (mode_r == psrs_pkg::MODE_LOCKED) begin
          res_nxt = psrs_pkg::RES_LOCKED;
        end else if (mode_r != psrs_pkg::MODE_IDLE) begin
          res_nxt = psrs_pkg::RES_COOLDOWN;
        end
      end
      psrs_pkg::CMD_OFF: begin
        if (mode_r == psrs_pkg::MODE_LOCKED) begin
          res_nxt = psrs_pkg::RES_LOCKED;
        end else if (!(mode_r inside {psrs_pkg::MODE_STARTING, psrs_pkg::MODE_RUNNING})) begin
          res_nxt = psrs_pkg::RES_ALREADY_OFF;
        end
      end
      psrs_pkg::CMD_UNLOCK: begin
        if (mode_r != psrs_pkg::MODE_LOCKED) begin
          res_nxt = psrs_pkg::RES_ALREADY_OFF;
        end
      end
      default: ;
    endcase

    evt_nxt = psrs_pkg::EVT_NONE;
    if (cmd == psrs_pkg::CMD_TICK) begin
      if (mode_r != psrs_pkg::MODE_COOLDOWN && mode_nxt == psrs_pkg::MODE_COOLDOWN) begin
        evt_nxt = psrs_pkg::EVT_CD_START;
      end else if (mode_r == psrs_pkg::MODE_COOLDOWN && mode_nxt == psrs_pkg::MODE_IDLE) begin
        evt_nxt = psrs_pkg::EVT_CD_END;
      end
    end
    evt_ms_nxt = (evt_nxt == psrs_pkg::EVT_CD_START) ? cooldown_r : '0;

    // Remaining time fits the register width whenever the counter is below it.
    nxt_ext   = CMP_W'(elapsed_nxt);
    left_diff = CMP_W'(cooldown_r) - nxt_ext;
    if (mode_nxt == psrs_pkg::MODE_COOLDOWN && nxt_ext < CMP_W'(cooldown_r)) begin
      left_ms_nxt = left_diff[REG_W-1:0];
    end else begin
      left_ms_nxt = '0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starter_time_r <= psrs_pkg::STARTER_TIME_RST;
      stop_pulse_r   <= psrs_pkg::STOP_PULSE_RST;
      cooldown_r     <= psrs_pkg::COOLDOWN_RST;
      grace_r        <= psrs_pkg::GRACE_RST;
    end else if (cfg_acc) begin
      case (cfg_ch.reg_index)
        psrs_pkg::REG_STARTER_TIME: starter_time_r <= cfg_ch.wr_data;
        psrs_pkg::REG_STOP_PULSE:   stop_pulse_r   <= cfg_ch.wr_data;
        psrs_pkg::REG_COOLDOWN:     cooldown_r     <= cfg_ch.wr_data;
        psrs_pkg::REG_GRACE:        grace_r        <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= psrs_pkg::MODE_IDLE;
      elapsed_r <= '0;
      starter_r <= 1'b0;
      coil_r    <= 1'b0;
      stop_r    <= 1'b0;
    end else if (in_acc) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      starter_r <= starter_nxt;
      coil_r    <= coil_nxt;
      stop_r    <= stop_nxt;
    end
  end

  // State stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
    end else if (s2_ld) begin
      s1_v_r <= 1'b0;
    end
  end

  // State stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_res_r     <= res_nxt;
      s1_mode_r    <= mode_nxt;
      s1_starter_r <= starter_nxt;
      s1_coil_r    <= coil_nxt;
      s1_stop_r    <= stop_nxt;
      s1_evt_r     <= evt_nxt;
      s1_evt_ms_r  <= evt_ms_nxt;
      s1_left_ms_r <= left_ms_nxt;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_ld) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  // Output register payload with the seconds conversion.
  always_ff @(posedge clk) begin
    if (s2_ld) begin
      out_res_r     <= s1_res_r;
      out_mode_r    <= s1_mode_r;
      out_starter_r <= s1_starter_r;
      out_coil_r    <= s1_coil_r;
      out_stop_r    <= s1_stop_r;
      out_evt_r     <= s1_evt_r;
      out_evt_s_r   <= psrs_pkg::ms_to_secs(s1_evt_ms_r);
      out_left_s_r  <= psrs_pkg::ms_to_secs(s1_left_ms_r);
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.result_code     = out_res_r;
  assign out_ch.state_code      = out_mode_r;
  assign out_ch.starter_relay   = out_starter_r;
  assign out_ch.coil_relay      = out_coil_r;
  assign out_ch.stop_relay      = out_stop_r;
  assign out_ch.event_code      = out_evt_r;
  assign out_ch.event_seconds   = out_evt_s_r;
  assign out_ch.cooldown_left_s = out_left_s_r;

endmodule

`default_nettype wire

FILE: rtl/core/psrs_checker.sv
`default_nettype none

module psrs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [psrs_pkg::CODE_W-1:0] result_code,
  input wire logic [psrs_pkg::CODE_W-1:0] state_code,
  input wire logic                        starter_relay,
  input wire logic                        coil_relay,
  input wire logic                        stop_relay,
  input wire logic [psrs_pkg::EVT_W-1:0]  event_code,
  input wire logic [psrs_pkg::SECS_W-1:0] event_seconds,
  input wire logic [psrs_pkg::SECS_W-1:0] cooldown_left_s
);

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A result that is not taken stays offered and unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_code) && $stable(state_code)
      && $stable(starter_relay) && $stable(coil_relay) && $stable(stop_relay)
      && $stable(event_code) && $stable(event_seconds) && $stable(cooldown_left_s))
    else $error("stalled result changed");

  // The starter winding is driven exactly while starting, only with the coil and never with the stop contact.
  a_starter_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (starter_relay == (state_code == psrs_pkg::MODE_STARTING))
      && !(starter_relay && stop_relay) && (!starter_relay || coil_relay))
    else $error("starter relay inconsistent with state");

  // Cooldown figures appear only in cooldown, and a start event lands in cooldown.
  a_cooldown_info: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_code == psrs_pkg::MODE_COOLDOWN || cooldown_left_s == '0)
      && (event_code == psrs_pkg::EVT_CD_START || event_seconds == '0)
      && (event_code != psrs_pkg::EVT_CD_START || state_code == psrs_pkg::MODE_COOLDOWN))
    else $error("cooldown information outside cooldown");

endmodule

bind pump_starter_relay_sequencer_unit psrs_checker u_psrs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .result_code     (out_ch.result_code),
  .state_code      (out_ch.state_code),
  .starter_relay   (out_ch.starter_relay),
  .coil_relay      (out_ch.coil_relay),
  .stop_relay      (out_ch.stop_relay),
  .event_code      (out_ch.event_code),
  .event_seconds   (out_ch.event_seconds),
  .cooldown_left_s (out_ch.cooldown_left_s)
);

`default_nettype wire
